// File: design/qes_pkg.sv
// Shared types, constants and helpers for the quantized even splitter.
`default_nettype none

package qes_pkg;

  localparam int MAX_PORTS   = 16;
  localparam int PORT_W      = 4;   // port_index field width
  localparam int PCOUNT_W    = 5;   // port_count register width
  localparam int DATA_W      = 32;  // sample and share width
  localparam int QUANT_W     = 31;  // quantum register width
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 31;  // widest register
  localparam int OUT_TDATA_W = 40;  // port_index + share_value, padded to bytes
  localparam int OUT_PAD_W   = OUT_TDATA_W - PORT_W - DATA_W;
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_PTR_W  = 1;
  localparam int FIFO_CNT_W  = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_QUANTUM    = 1'd0;
  localparam cfg_idx_t REG_PORT_COUNT = 1'd1;

  localparam logic [DATA_W-1:0] SHARE_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SHARE_MIN = 32'h8000_0000;

  // Per-item split plan handed from the front to the back.
  typedef struct packed {
    logic signed [DATA_W-1:0] base;  // floor(q / n)
    logic [PORT_W-1:0]        rest;  // q mod n, ports below this get one more step
  } share_plan_t;

  // Clamp the port count register to 1 .. MAX_PORTS.
  function automatic logic [PCOUNT_W-1:0] eff_ports(input logic [PCOUNT_W-1:0] pc);
    logic [PCOUNT_W-1:0] n;
    if (pc == '0) begin
      n = PCOUNT_W'(1);
    end else if (pc > PCOUNT_W'(MAX_PORTS)) begin
      n = PCOUNT_W'(MAX_PORTS);
    end else begin
      n = pc;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: design/quantized_even_splitter.sv
// Top level of the quantized even splitter: config registers, front, queue and back.
// Dataflow: a sample goes through the two radix-4 dividers of the front in turn, then the
//   queue and the back; the back emits one share per cycle unless the output stalls.
// Overlap: the front takes a new sample once its first divider hands its quotient on,
//   while its second divider splits; the back takes the next plan with its last share.
// Reset (rst, synchronous): clears all handshake and sequencing state; quantum returns
//   to 1.0 (65536) and port count to 1. No memory clearing pass is needed.
`default_nettype none

module quantized_even_splitter (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Configuration write port
  input  wire logic                                cfg_we,
  input  wire qes_pkg::cfg_idx_t                   cfg_index,
  input  wire logic [qes_pkg::CFG_DATA_W-1:0]      cfg_data,
  // Sample stream
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [qes_pkg::DATA_W-1:0]          s_axis_tdata,  // [31:0] sample_value
  // Share stream
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic [qes_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,  // [3:0] port_index,
                                                                  // [35:4] share_value,
                                                                  // [39:36] zero
  output logic                                     m_axis_tlast   // last_share
);

  logic [qes_pkg::QUANT_W-1:0]  quantum;
  logic [qes_pkg::PCOUNT_W-1:0] port_count;

  logic                 plan_valid, plan_ready;
  qes_pkg::share_plan_t plan;
  logic                 q_valid, q_ready;
  qes_pkg::share_plan_t q_plan;

  logic [qes_pkg::PORT_W-1:0] out_port;
  logic [qes_pkg::DATA_W-1:0] out_share;

  // Configuration registers; user writes only while the datapath is drained, not enforced.
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum    <= qes_pkg::QUANT_W'(65536);
      port_count <= qes_pkg::PCOUNT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        qes_pkg::REG_QUANTUM:    quantum    <= cfg_data;
        qes_pkg::REG_PORT_COUNT: port_count <= cfg_data[qes_pkg::PCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: quantize and split; accepts a new sample as soon as its first divider frees up.
  qes_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .sample_value (signed'(s_axis_tdata)),
    .quantum      (quantum),
    .port_count   (port_count),
    .out_valid    (plan_valid),
    .out_ready    (plan_ready),
    .out_plan     (plan)
  );

  // Queue decouples the divider timing from the share emission.
  qes_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (plan_valid),
    .wr_ready (plan_ready),
    .wr_data  (plan),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_plan)
  );

  // Back: generate, multiply, saturate stages; one share per cycle unless output stalls.
  qes_back u_back (
    .clk        (clk),
    .rst        (rst),
    .plan_valid (q_valid),
    .plan_ready (q_ready),
    .plan       (q_plan),
    .quantum    (quantum),
    .port_count (port_count),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_port   (out_port),
    .out_share  (out_share),
    .out_last   (m_axis_tlast)
  );

  // Pack the share transfer, port index in the low bits.
  assign m_axis_tdata = {{qes_pkg::OUT_PAD_W{1'b0}}, out_share, out_port};

endmodule

`default_nettype wire

// File: design/qes_div.sv
// Radix-4 iterative floor divider: signed dividend by a positive unsigned divisor.
`default_nettype none

module qes_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] dividend,
  input  wire logic [31:0]        divisor,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      quotient,
  output logic [31:0]             remainder
);

  typedef enum logic [3:0] {
    DIV_IDLE = 4'b0001,
    DIV_RUN  = 4'b0010,
    DIV_FIX  = 4'b0100,
    DIV_DONE = 4'b1000
  } div_state_t;

  div_state_t  state, state_next;
  logic [31:0] quo, rem, dvd, dsr;
  logic [33:0] dsr3;
  logic        neg;
  logic [3:0]  cnt;
  logic        start;
  logic        rnz;
  logic [33:0] r4;
  logic [34:0] d1, d2, d3;
  logic [1:0]  digit;
  logic [31:0] rem_sel;
  logic [31:0] dividend_u;

  assign in_ready   = (state == DIV_IDLE) || ((state == DIV_DONE) && out_ready);
  assign start      = in_valid && in_ready;
  assign out_valid  = (state == DIV_DONE);
  assign rnz        = (rem != '0);
  assign dividend_u = 32'(dividend);

  // Two quotient bits per cycle: compare against 3b, 2b and b in parallel.
  always_comb begin
    r4 = {rem, dvd[31:30]};
    d1 = {1'b0, r4} - {3'b000, dsr};
    d2 = {1'b0, r4} - {2'b00, dsr, 1'b0};
    d3 = {1'b0, r4} - {1'b0, dsr3};
    priority if (!d3[34]) begin
      digit   = 2'd3;
      rem_sel = d3[31:0];
    end else if (!d2[34]) begin
      digit   = 2'd2;
      rem_sel = d2[31:0];
    end else if (!d1[34]) begin
      digit   = 2'd1;
      rem_sel = d1[31:0];
    end else begin
      digit   = 2'd0;
      rem_sel = r4[31:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      DIV_IDLE: if (start) state_next = DIV_RUN;
      DIV_RUN:  if (cnt == 4'd15) state_next = DIV_FIX;
      DIV_FIX:  state_next = DIV_DONE;
      DIV_DONE: begin
        if (start) begin
          state_next = DIV_RUN;
        end else if (out_ready) begin
          state_next = DIV_IDLE;
        end
      end
      default:  state_next = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= dividend[31];
      dvd  <= dividend[31] ? (~dividend_u + 32'd1) : dividend_u;
      dsr  <= divisor;
      dsr3 <= {2'b00, divisor} + {1'b0, divisor, 1'b0};
      rem  <= '0;
      quo  <= '0;
      cnt  <= '0;
    end else if (state == DIV_RUN) begin
      rem <= rem_sel;
      quo <= {quo[29:0], digit};
      dvd <= {dvd[29:0], 2'b00};
      cnt <= cnt + 4'd1;
    end else if (state == DIV_FIX) begin
      // Round toward minus infinity for a negative dividend.
      quotient  <= neg ? (rnz ? ~quo : ~quo + 32'd1) : quo;
      remainder <= (neg && rnz) ? (dsr - rem) : rem;
    end
  end

endmodule

`default_nettype wire

// File: design/qes_front.sv
// Front end: quantize the sample to steps, then split the steps by the port count.
`default_nettype none

module qes_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic signed [qes_pkg::DATA_W-1:0] sample_value,
  input  wire logic [qes_pkg::QUANT_W-1:0]      quantum,
  input  wire logic [qes_pkg::PCOUNT_W-1:0]     port_count,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output qes_pkg::share_plan_t                  out_plan
);

  logic                              q_valid, q_ready;
  logic signed [qes_pkg::DATA_W-1:0] steps_q;
  logic [qes_pkg::DATA_W-1:0]        q_rem;
  logic signed [qes_pkg::DATA_W-1:0] base_q;
  logic [qes_pkg::DATA_W-1:0]        rest_q;
  logic [qes_pkg::DATA_W-1:0]        n_ext;

  assign n_ext = qes_pkg::DATA_W'(qes_pkg::eff_ports(port_count));

  // q = floor(sample / quantum); a zero quantum gives a don't-care q, zeroed later by the multiply
  qes_div u_div_quant (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .dividend  (sample_value),
    .divisor   ({1'b0, quantum}),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .quotient  (steps_q),
    .remainder (q_rem)
  );

  // base = floor(q / n), rest = q mod n
  qes_div u_div_ports (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .dividend  (steps_q),
    .divisor   (n_ext),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .quotient  (base_q),
    .remainder (rest_q)
  );

  assign out_plan.base = base_q;
  assign out_plan.rest = rest_q[qes_pkg::PORT_W-1:0];

`ifndef SYNTHESIS
  a_quant_rem: assert property (@(posedge clk) disable iff (rst)
    (q_valid && (quantum != '0)) |-> (q_rem < qes_pkg::DATA_W'(quantum)))
    else $error("quantizer remainder not below the step size");

  a_rest_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rest_q < n_ext))
    else $error("split remainder not below the port count");

  a_steps_hold: assert property (@(posedge clk) disable iff (rst)
    (q_valid && !q_ready) |=> (q_valid && $stable(steps_q)))
    else $error("step count changed while waiting for the split divider");
`endif

endmodule

`default_nettype wire

// File: design/qes_fifo.sv
// Two-entry queue of split plans between the front and the back.
`default_nettype none

module qes_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 wr_valid,
  output logic                      wr_ready,
  input  wire qes_pkg::share_plan_t wr_data,
  output logic                      rd_valid,
  input  wire logic                 rd_ready,
  output qes_pkg::share_plan_t      rd_data
);

  qes_pkg::share_plan_t                 entries [qes_pkg::FIFO_DEPTH];
  logic [qes_pkg::FIFO_PTR_W-1:0]       wr_ptr, rd_ptr;
  logic [qes_pkg::FIFO_CNT_W-1:0]       count;
  logic                                 push, pop;

  assign wr_ready = (count != qes_pkg::FIFO_CNT_W'(qes_pkg::FIFO_DEPTH));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// File: design/qes_back.sv
// Back end: walk the ports of one plan, scale each share by the quantum, saturate.
`default_nettype none

module qes_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         plan_valid,
  output logic                              plan_ready,
  input  wire qes_pkg::share_plan_t         plan,
  input  wire logic [qes_pkg::QUANT_W-1:0]  quantum,
  input  wire logic [qes_pkg::PCOUNT_W-1:0] port_count,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [qes_pkg::PORT_W-1:0]        out_port,
  output logic [qes_pkg::DATA_W-1:0]        out_share,
  output logic                              out_last
);

  logic                              en;
  logic [qes_pkg::PORT_W-1:0]        n_m1;
  logic                              active;
  logic signed [qes_pkg::DATA_W-1:0] cur_base;
  logic [qes_pkg::PORT_W-1:0]        cur_rest;
  logic [qes_pkg::PORT_W-1:0]        idx;
  logic                              last_now;
  logic                              s1_valid, s1_last;
  logic [qes_pkg::PORT_W-1:0]        s1_idx;
  logic signed [qes_pkg::DATA_W:0]   s1_steps;
  logic                              s2_valid, s2_last;
  logic [qes_pkg::PORT_W-1:0]        s2_idx;
  logic signed [2*qes_pkg::DATA_W:0] prod;
  logic signed [qes_pkg::DATA_W-1:0] qt_s;
  logic [qes_pkg::DATA_W-1:0]        sat_val;
  logic signed [qes_pkg::DATA_W:0]   base_ext;

  assign en       = !out_valid || out_ready;
  assign n_m1     = qes_pkg::PORT_W'(qes_pkg::eff_ports(port_count) - qes_pkg::PCOUNT_W'(1));
  assign last_now = (idx == n_m1);
  assign plan_ready = en && (!active || last_now);
  assign qt_s     = signed'({1'b0, quantum});
  assign base_ext = {cur_base[qes_pkg::DATA_W-1], cur_base};

  // Saturate when the upper bits are not a plain sign extension.
  always_comb begin
    if ((prod[2*qes_pkg::DATA_W:qes_pkg::DATA_W-1] == '0) ||
        (prod[2*qes_pkg::DATA_W:qes_pkg::DATA_W-1] == '1)) begin
      sat_val = prod[qes_pkg::DATA_W-1:0];
    end else if (prod[2*qes_pkg::DATA_W]) begin
      sat_val = qes_pkg::SHARE_MIN;
    end else begin
      sat_val = qes_pkg::SHARE_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en) begin
        s1_valid  <= active;
        s2_valid  <= s1_valid;
        out_valid <= s2_valid;
      end
      if (plan_ready) begin
        active <= plan_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (active) begin
        s1_idx   <= idx;
        s1_last  <= last_now;
        s1_steps <= (idx < cur_rest) ? base_ext + 33'sd1 : base_ext;
      end
      if (plan_ready && plan_valid) begin
        cur_base <= plan.base;
        cur_rest <= plan.rest;
        idx      <= '0;
      end else if (active) begin
        idx      <= idx + 1'b1;
      end
      s2_idx    <= s1_idx;
      s2_last   <= s1_last;
      prod      <= s1_steps * qt_s;
      out_port  <= s2_idx;
      out_last  <= s2_last;
      out_share <= sat_val;
    end
  end

`ifndef SYNTHESIS
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    (active && en && !last_now) |=> (idx == $past(idx) + 1'b1))
    else $error("port index did not advance by one within a run");

  a_last_tag: assert property (@(posedge clk) disable iff (rst)
    (active && en && last_now) |=> (s1_valid && s1_last))
    else $error("final port of a run not tagged last");

  a_run_holds: assert property (@(posedge clk) disable iff (rst)
    (active && en && !last_now) |=> (active && s1_valid && !s1_last))
    else $error("run ended before its final port");
`endif

endmodule

`default_nettype wire
